// ----- design/wsfr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the websocket frame receiver.
// No dependencies; every other design file but wsfr_if refers to it by scoped names.
package wsfr_pkg;

    // Widths and sizes
    localparam int LENGTH_BITS = 64;
    localparam int MSG_CNT_W   = 24;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Register map (register index taken from paddr[2])
    localparam logic REG_MAX_MSG = 1'b0;
    localparam logic [MSG_CNT_W-1:0] MAX_MSG_RESET = 24'd4096;

    // Header byte fields
    localparam logic [7:0] HDR_RSV_MASK = 8'b0111_0000;
    localparam logic [3:0] OP_CONT       = 4'd0;
    localparam logic [3:0] OP_TEXT       = 4'd1;
    localparam logic [3:0] OP_CONN_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING       = 4'd9;
    localparam logic [3:0] OP_PONG       = 4'd10;
    localparam logic [6:0] LEN_IS_16 = 7'd126;
    localparam logic [6:0] LEN_IS_64 = 7'd127;

    // Close status codes
    localparam logic [9:0] STATUS_NONE   = 10'd0;
    localparam logic [9:0] STATUS_PROTO  = 10'd1002;
    localparam logic [9:0] STATUS_UNSUPP = 10'd1003;

    typedef enum logic [3:0] {
        EV_MSG_BYTE    = 4'd0,
        EV_MSG_END     = 4'd1,
        EV_PING_BYTE   = 4'd2,
        EV_EMPTY_PING  = 4'd3,
        EV_CLOSE       = 4'd4,
        EV_RSV_ERR     = 4'd5,
        EV_ORPHAN      = 4'd6,
        EV_DUP_START   = 4'd7,
        EV_UNSUPPORTED = 4'd8,
        EV_UNMASKED    = 4'd9,
        EV_BAD_CONTROL = 4'd10
    } t_event;

    // What the back end does with a queued command
    typedef enum logic [1:0] {
        K_START = 2'd0,   // new text message: clear delivered count
        K_MSG   = 2'd1,   // message byte, subject to the limit
        K_PING  = 2'd2,   // ping byte
        K_FIXED = 2'd3    // event without payload
    } t_kind;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_LEN16   = 3'd2,
        PH_LEN64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        t_event     ev;
        logic [7:0] data;
        logic [7:0] mask;
        logic       last;
    } t_cmd;

    function automatic logic [9:0] close_status_of(input t_event ev);
        logic [9:0] st;
        case (ev) inside
            EV_RSV_ERR, EV_ORPHAN, EV_DUP_START, EV_UNMASKED, EV_BAD_CONTROL:
                st = STATUS_PROTO;
            EV_UNSUPPORTED:
                st = STATUS_UNSUPP;
            default:
                st = STATUS_NONE;
        endcase
        return st;
    endfunction

endpackage

// ----- design/wsfr_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: raw byte input and result event output.
// Uses no package.
interface wsfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] payload;
    logic       last;
    logic [9:0] close_status;
    modport source (output valid, output event_res, output payload, output last,
                    output close_status, input ready);
    modport sink   (input valid, input event_res, input payload, input last,
                    input close_status, output ready);
endinterface

// ----- design/wsfr_front.sv -----
`timescale 1ns / 1ps
// Header parser: takes one byte per clock while the queue is not full, tracks
// frame state and pushes commands into the queue. Depends on wsfr_pkg and wsfr_in_if.
module wsfr_front #(
    parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wsfr_in_if.sink         i_rx,
    input  logic            i_full,
    output logic            o_push,
    output wsfr_pkg::t_cmd  o_cmd
);

    wsfr_pkg::t_phase r_phase, n_phase;
    logic [2:0]             r_hcount, n_hcount;
    logic                   r_fin, n_fin;
    logic [3:0]             r_opcode, n_opcode;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [31:0]            r_mask, n_mask;
    logic [1:0]             r_mpos, n_mpos;
    logic                   r_open, n_open;
    logic                   r_dead, n_dead;

    logic                   accept;
    logic [7:0]             b;
    logic [3:0]             op;
    logic                   hdr_err;
    wsfr_pkg::t_event       hdr_ev;
    logic [LENGTH_BITS-1:0] len_shift;
    logic                   pay_end;
    logic [7:0]             mask_byte;

    // Take a byte whenever the queue has room
    assign i_rx.ready = !i_full;
    assign accept     = i_rx.valid && !i_full;
    assign b          = i_rx.rx_byte;
    assign op         = b[3:0];

    // Classify the first header byte; checks in priority order
    always_comb begin
        hdr_err = 1'b1;
        hdr_ev  = wsfr_pkg::EV_RSV_ERR;
        if ((b & wsfr_pkg::HDR_RSV_MASK) != 8'd0) begin
            hdr_ev = wsfr_pkg::EV_RSV_ERR;
        end else if (op[3]) begin
            hdr_err = (op > wsfr_pkg::OP_PONG);
            hdr_ev  = wsfr_pkg::EV_BAD_CONTROL;
        end else if (op == wsfr_pkg::OP_CONT && !r_open) begin
            hdr_ev = wsfr_pkg::EV_ORPHAN;
        end else if (op == wsfr_pkg::OP_TEXT && r_open) begin
            hdr_ev = wsfr_pkg::EV_DUP_START;
        end else if (op > wsfr_pkg::OP_TEXT) begin
            hdr_ev = wsfr_pkg::EV_UNSUPPORTED;
        end else begin
            hdr_err = 1'b0;
        end
    end

    // Shift a length byte in, saturating at all ones
    assign len_shift = (r_rem[LENGTH_BITS-1 -: 8] != 8'd0) ? '1
                                                           : {r_rem[LENGTH_BITS-9:0], b};
    assign pay_end   = (r_rem[LENGTH_BITS-1:1] == '0);

    // Pick the key byte for the current payload position
    always_comb begin
        case (r_mpos)
            2'd0:    mask_byte = r_mask[31:24];
            2'd1:    mask_byte = r_mask[23:16];
            2'd2:    mask_byte = r_mask[15:8];
            default: mask_byte = r_mask[7:0];
        endcase
    end

    // Next parse phase
    always_comb begin
        n_phase = r_phase;
        if (accept && !r_dead) begin
            unique case (r_phase)
                wsfr_pkg::PH_HDR0: begin
                    if (!hdr_err) n_phase = wsfr_pkg::PH_HDR1;
                end
                wsfr_pkg::PH_HDR1: begin
                    if (b[7]) begin
                        if (b[6:0] == wsfr_pkg::LEN_IS_16)      n_phase = wsfr_pkg::PH_LEN16;
                        else if (b[6:0] == wsfr_pkg::LEN_IS_64) n_phase = wsfr_pkg::PH_LEN64;
                        else                                    n_phase = wsfr_pkg::PH_MASK;
                    end
                end
                wsfr_pkg::PH_LEN16: begin
                    if (r_hcount >= 3'd1) n_phase = wsfr_pkg::PH_MASK;
                end
                wsfr_pkg::PH_LEN64: begin
                    if (r_hcount >= 3'd7) n_phase = wsfr_pkg::PH_MASK;
                end
                wsfr_pkg::PH_MASK: begin
                    if (r_hcount >= 3'd3) begin
                        n_phase = (r_rem != '0) ? wsfr_pkg::PH_PAYLOAD : wsfr_pkg::PH_HDR0;
                    end
                end
                wsfr_pkg::PH_PAYLOAD: begin
                    if (pay_end) n_phase = wsfr_pkg::PH_HDR0;
                end
                default: n_phase = wsfr_pkg::PH_HDR0;
            endcase
        end
    end

    // Frame state updates and command push
    always_comb begin
        n_hcount = r_hcount;
        n_fin    = r_fin;
        n_opcode = r_opcode;
        n_rem    = r_rem;
        n_mask   = r_mask;
        n_mpos   = r_mpos;
        n_open   = r_open;
        n_dead   = r_dead;
        o_push   = 1'b0;
        o_cmd    = '{kind: wsfr_pkg::K_FIXED, ev: wsfr_pkg::EV_CLOSE,
                     data: b, mask: mask_byte, last: 1'b0};
        if (accept && !r_dead) begin
            unique case (r_phase)
                wsfr_pkg::PH_HDR0: begin
                    n_fin    = b[7];
                    n_opcode = op;
                    n_hcount = 3'd0;
                    if (hdr_err) begin
                        n_dead    = 1'b1;
                        o_push    = 1'b1;
                        o_cmd.ev  = hdr_ev;
                    end else if (op == wsfr_pkg::OP_TEXT) begin
                        n_open     = 1'b1;
                        o_push     = 1'b1;
                        o_cmd.kind = wsfr_pkg::K_START;
                    end
                end
                wsfr_pkg::PH_HDR1: begin
                    n_hcount = 3'd0;
                    if (!b[7]) begin
                        n_dead   = 1'b1;
                        o_push   = 1'b1;
                        o_cmd.ev = wsfr_pkg::EV_UNMASKED;
                    end else if (b[6:0] == wsfr_pkg::LEN_IS_16 ||
                                 b[6:0] == wsfr_pkg::LEN_IS_64) begin
                        n_rem = '0;
                    end else begin
                        n_rem = {{(LENGTH_BITS-7){1'b0}}, b[6:0]};
                    end
                end
                wsfr_pkg::PH_LEN16, wsfr_pkg::PH_LEN64: begin
                    n_rem = len_shift;
                    if ((r_phase == wsfr_pkg::PH_LEN16 && r_hcount >= 3'd1) ||
                        (r_phase == wsfr_pkg::PH_LEN64 && r_hcount >= 3'd7)) begin
                        n_hcount = 3'd0;
                    end else begin
                        n_hcount = r_hcount + 3'd1;
                    end
                end
                wsfr_pkg::PH_MASK: begin
                    n_mask = {r_mask[23:0], b};
                    if (r_hcount >= 3'd3) begin
                        n_hcount = 3'd0;
                        n_mpos   = 2'd0;
                        // Empty frame: once the header is complete, report a final data frame, a ping or a close
                        if (r_rem == '0) begin
                            if (r_opcode <= wsfr_pkg::OP_TEXT) begin
                                if (r_fin) begin
                                    n_open     = 1'b0;
                                    o_push     = 1'b1;
                                    o_cmd.ev   = wsfr_pkg::EV_MSG_END;
                                    o_cmd.last = 1'b1;
                                end
                            end else if (r_opcode == wsfr_pkg::OP_PING) begin
                                o_push     = 1'b1;
                                o_cmd.ev   = wsfr_pkg::EV_EMPTY_PING;
                                o_cmd.last = 1'b1;
                            end else if (r_opcode == wsfr_pkg::OP_CONN_CLOSE) begin
                                n_dead = 1'b1;
                                o_push = 1'b1;
                            end
                        end
                    end else begin
                        n_hcount = r_hcount + 3'd1;
                    end
                end
                wsfr_pkg::PH_PAYLOAD: begin
                    n_mpos = r_mpos + 2'd1;
                    if (r_rem != '0) n_rem = r_rem - LENGTH_BITS'(1);
                    if (r_opcode <= wsfr_pkg::OP_TEXT) begin
                        if (pay_end && r_fin) n_open = 1'b0;
                        o_push     = 1'b1;
                        o_cmd.kind = wsfr_pkg::K_MSG;
                        o_cmd.last = pay_end && r_fin;
                    end else if (r_opcode == wsfr_pkg::OP_PING) begin
                        o_push     = 1'b1;
                        o_cmd.kind = wsfr_pkg::K_PING;
                        o_cmd.last = pay_end;
                    end else if (r_opcode == wsfr_pkg::OP_CONN_CLOSE && pay_end) begin
                        n_dead = 1'b1;
                        o_push = 1'b1;
                    end
                end
                default: begin
                    n_hcount = 3'd0;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsfr_pkg::PH_HDR0;
            r_hcount <= 3'd0;
            r_fin    <= 1'b0;
            r_opcode <= 4'd0;
            r_mpos   <= 2'd0;
            r_open   <= 1'b0;
            r_dead   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_mpos   <= n_mpos;
            r_open   <= n_open;
            r_dead   <= n_dead;
        end
    end

    // Length and key
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_mask <= n_mask;
    end

`ifndef SYNTHESIS
    a_dead_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dead |=> r_dead)
        else $error("dead flag cleared without reset");
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wsfr_pkg::PH_PAYLOAD) |-> (r_rem != '0))
        else $error("payload phase with zero remaining length");
`endif

endmodule

// ----- design/wsfr_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the parser and the event stage.
// Depends on wsfr_pkg.
module wsfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsfr_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output wsfr_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    wsfr_pkg::t_cmd                r_mem [wsfr_pkg::QDEPTH];
    logic [wsfr_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [wsfr_pkg::QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == wsfr_pkg::QCNT_W'(wsfr_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // Store a pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + wsfr_pkg::QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + wsfr_pkg::QPTR_W'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + wsfr_pkg::QCNT_W'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - wsfr_pkg::QCNT_W'(1);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");
`endif

endmodule

// ----- design/wsfr_back.sv -----
`timescale 1ns / 1ps
// Event stage: unmasks payload, applies the message limit and holds the
// result register. Depends on wsfr_pkg and wsfr_out_if.
module wsfr_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wsfr_pkg::t_cmd                   i_cmd,
    input  logic                             i_empty,
    output logic                             o_pop,
    input  logic [wsfr_pkg::MSG_CNT_W-1:0]   i_max_msg,
    wsfr_out_if.source                       o_ev
);

    logic                            r_valid, n_valid;
    wsfr_pkg::t_event                r_event, n_event;
    logic [7:0]                      r_payload, n_payload;
    logic                            r_last, n_last;
    logic [wsfr_pkg::MSG_CNT_W-1:0]  r_count, n_count;
    logic [7:0]                      plain;

    // Pop when the result register is free or being taken
    assign o_pop = !i_empty && (!r_valid || o_ev.ready);
    assign plain = i_cmd.data ^ i_cmd.mask;

    always_comb begin
        n_valid   = r_valid && !o_ev.ready;
        n_event   = r_event;
        n_payload = r_payload;
        n_last    = r_last;
        n_count   = r_count;
        if (o_pop) begin
            n_valid   = 1'b0;
            n_event   = i_cmd.ev;
            n_payload = 8'd0;
            n_last    = i_cmd.last;
            case (i_cmd.kind)
                wsfr_pkg::K_START: begin
                    n_count = '0;
                end
                wsfr_pkg::K_MSG: begin
                    if (r_count < i_max_msg) begin
                        n_count   = r_count + wsfr_pkg::MSG_CNT_W'(1);
                        n_valid   = 1'b1;
                        n_event   = wsfr_pkg::EV_MSG_BYTE;
                        n_payload = plain;
                    end else if (i_cmd.last) begin
                        n_valid = 1'b1;
                        n_event = wsfr_pkg::EV_MSG_END;
                    end
                end
                wsfr_pkg::K_PING: begin
                    n_valid   = 1'b1;
                    n_event   = wsfr_pkg::EV_PING_BYTE;
                    n_payload = plain;
                end
                default: begin
                    n_valid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_event   <= n_event;
        r_payload <= n_payload;
        r_last    <= n_last;
    end

    assign o_ev.valid        = r_valid;
    assign o_ev.event_res    = r_event;
    assign o_ev.payload      = r_payload;
    assign o_ev.last         = r_last;
    assign o_ev.close_status = wsfr_pkg::close_status_of(r_event);

`ifndef SYNTHESIS
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_event == wsfr_pkg::EV_MSG_BYTE ||
                                 r_event == wsfr_pkg::EV_MSG_END ||
                                 r_event == wsfr_pkg::EV_PING_BYTE ||
                                 r_event == wsfr_pkg::EV_EMPTY_PING))
        else $error("last flag on an event without payload stream");
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_event != wsfr_pkg::EV_MSG_BYTE &&
         r_event != wsfr_pkg::EV_PING_BYTE) |-> (r_payload == 8'd0))
        else $error("payload on a non-byte event");
`endif

endmodule

// ----- design/websocket_frame_receiver.sv -----
`timescale 1ns / 1ps
// Path: an accepted byte is parsed combinationally, stored in the queue and then
// popped into the result register. Throughput: one byte per clock while the queue
// has room; the four-entry queue can push and pop in the same cycle.
// Reset: i_rst_n synchronous, active low; clears parser, queue and result
// register and sets max_message_bytes to 4096. No clearing pass.
module websocket_frame_receiver #(
    parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wsfr_in_if.sink                        i_rx,
    wsfr_out_if.source                     o_ev,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wsfr_pkg::PADDR_W-1:0]   paddr,
    input  logic [wsfr_pkg::PDATA_W-1:0]   pwdata,
    output logic [wsfr_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [wsfr_pkg::MSG_CNT_W-1:0] r_max_msg;
    logic                           q_push, q_pop, q_full, q_empty;
    wsfr_pkg::t_cmd                 push_cmd, head_cmd;
    logic                           sel_max;

    // Register port
    assign pready  = 1'b1;
    assign sel_max = (paddr[2] == wsfr_pkg::REG_MAX_MSG);
    assign prdata  = sel_max ? wsfr_pkg::PDATA_W'(r_max_msg) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_msg <= wsfr_pkg::MAX_MSG_RESET;
        end else if (psel && penable && pwrite && sel_max) begin
            r_max_msg <= pwdata[wsfr_pkg::MSG_CNT_W-1:0];
        end
    end

    wsfr_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (push_cmd)
    );

    wsfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    wsfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_empty   (q_empty),
        .o_pop     (q_pop),
        .i_max_msg (r_max_msg),
        .o_ev      (o_ev)
    );

endmodule
